>>> rtl/dollar_escape_decoder_assert.svh
// Assertion macros used by the checker of the escape decoder.
`ifndef DOLLAR_ESCAPE_DECODER_ASSERT_SVH
`define DOLLAR_ESCAPE_DECODER_ASSERT_SVH

// Property checked on every rising edge of clk while reset is released.
`define DED_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked on every rising edge of clk, reset included.
`define DED_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/dedec_pkg.sv
// Types, character codes and decode functions of the dollar escape decoder.
package dedec_pkg;

	// Escape progress within one text.
	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_ESC   = 2'd1,
		PH_HEX   = 2'd2
	} phase_t;

	localparam logic [7:0] DOLLAR_CHAR     = 8'h24;
	localparam logic [7:0] LINE_FEED       = 8'h0A;
	localparam logic [7:0] FORM_FEED       = 8'h0C;
	localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;
	localparam logic [7:0] HORIZONTAL_TAB  = 8'h09;
	localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_final;
	} in_item_t;

	typedef struct packed {
		logic [7:0] decoded_byte;
		logic       byte_valid;
		logic       text_done;
		logic       bad_escape;
	} result_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] high_nibble;
		logic       error_seen;
	} dec_state_t;

	localparam dec_state_t STATE_RESET = '{phase: PH_PLAIN, high_nibble: 4'd0,
		error_seen: 1'b0};

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] chr;
	} simple_t;

	// Value of an ASCII hex digit, either letter case.
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok = 1'b1;
		r.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.val = 4'(c - 8'h61) + HEX_LETTER_BASE;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.val = 4'(c - 8'h41) + HEX_LETTER_BASE;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	// Character that a one-character escape stands for.
	function automatic simple_t simple_decode(input logic [7:0] c);
		simple_t r;
		r.ok = 1'b1;
		r.chr = 8'h00;
		unique case (c) inside
			8'h24, 8'h27, 8'h22, 8'h7B, 8'h7D, 8'h3A, 8'h20: r.chr = c;
			8'h6C, 8'h4C, 8'h6E, 8'h4E:                     r.chr = LINE_FEED;
			8'h70, 8'h50:                                   r.chr = FORM_FEED;
			8'h72, 8'h52:                                   r.chr = CARRIAGE_RETURN;
			8'h74, 8'h54:                                   r.chr = HORIZONTAL_TAB;
			default:                                        r.ok = 1'b0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/dollar_escape_decoder.sv
// Top level of the dollar escape decoder: input register, decode and result register.
// The block decodes a byte stream in which a dollar sign opens an escape.
// Input channel item_valid / item_stall / item carries one text byte and a
// final-byte flag per transfer. Output channel result_valid / result_stall /
// result carries one decoded byte, or the end-of-text status, per transfer.
// A dollar sign, the first digit of a hex pair, a byte that raises an error
// and any byte dropped after it give no output transfer; the final byte of a text always gives one.
// An input byte passes through the input register and then the result
// register. Unless the receiver stalls, both registers move every cycle,
// so the block takes one byte per cycle without gaps, and the escape
// state update is the loop that sets that rate.
// item_stall rises only when the input register holds a byte and the result
// register holds a result that the receiver is stalling; a stalled result
// holds its value until it is taken.
// Reset empties both registers and returns the escape state to plain text
// with no error pending.
module dollar_escape_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  dedec_pkg::in_item_t   item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output dedec_pkg::result_t    result
);

	logic                  valid_s1;
	dedec_pkg::in_item_t   item_s1;
	dedec_pkg::dec_state_t state_q;
	dedec_pkg::dec_state_t state_next;
	logic                  emit;
	dedec_pkg::result_t    res;
	logic                  valid_s2;
	dedec_pkg::result_t    result_s2;
	logic                  out_free;
	logic                  fire_s1;
	logic                  accept;

	// The result register can load when it is empty or its transfer completes.
	assign out_free = !valid_s2 || !result_stall;
	assign fire_s1 = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign accept = item_valid && !item_stall;

	dedec_core u_core (
		.st      (state_q),
		.item    (item_s1),
		.st_next (state_next),
		.emit    (emit),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q <= dedec_pkg::STATE_RESET;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (fire_s1) begin
				state_q <= state_next;
			end
			if (out_free) begin
				valid_s2 <= fire_s1 && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (fire_s1 && emit) begin
			result_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign result = result_s2;

endmodule

>>> rtl/dedec_core.sv
// Per-byte decode: next escape state and the result of one input byte.
module dedec_core (
	input  dedec_pkg::dec_state_t st,
	input  dedec_pkg::in_item_t   item,
	output dedec_pkg::dec_state_t st_next,
	output logic                  emit,
	output dedec_pkg::result_t    res
);

	dedec_pkg::hex_t    hx;
	dedec_pkg::simple_t sm;
	dedec_pkg::dec_state_t nxt;
	logic       have;
	logic [7:0] chr;
	logic       err;

	assign hx = dedec_pkg::hex_decode(item.text_byte);
	assign sm = dedec_pkg::simple_decode(item.text_byte);

	always_comb begin
		nxt = st;
		have = 1'b0;
		chr = 8'h00;
		err = st.error_seen;
		if (!st.error_seen) begin
			unique case (st.phase)
				dedec_pkg::PH_ESC: begin
					if (sm.ok) begin
						have = 1'b1;
						chr = sm.chr;
						nxt.phase = dedec_pkg::PH_PLAIN;
					end else if (hx.ok) begin
						nxt.high_nibble = hx.val;
						nxt.phase = dedec_pkg::PH_HEX;
					end else begin
						err = 1'b1;
					end
				end
				dedec_pkg::PH_HEX: begin
					if (hx.ok) begin
						have = 1'b1;
						chr = {st.high_nibble, hx.val};
						nxt.phase = dedec_pkg::PH_PLAIN;
					end else begin
						err = 1'b1;
					end
				end
				default: begin
					if (item.text_byte == dedec_pkg::DOLLAR_CHAR) begin
						nxt.phase = dedec_pkg::PH_ESC;
					end else begin
						have = 1'b1;
						chr = item.text_byte;
						nxt.phase = dedec_pkg::PH_PLAIN;
					end
				end
			endcase
			// An escape left open at the end of the text is an error too.
			if (item.is_final && nxt.phase != dedec_pkg::PH_PLAIN) begin
				err = 1'b1;
			end
		end
		nxt.error_seen = err;

		if (item.is_final) begin
			emit = 1'b1;
			res.decoded_byte = (have && !err) ? chr : 8'h00;
			res.byte_valid = have && !err;
			res.text_done = 1'b1;
			res.bad_escape = err;
			st_next = dedec_pkg::STATE_RESET;
		end else begin
			emit = have && !err;
			res.decoded_byte = chr;
			res.byte_valid = 1'b1;
			res.text_done = 1'b0;
			res.bad_escape = 1'b0;
			st_next = nxt;
		end
	end

endmodule

>>> rtl/dedec_checker.sv
// Port-level checker of the dollar escape decoder and its bind.
`include "dollar_escape_decoder_assert.svh"

module dedec_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input dedec_pkg::result_t result
);

	`DED_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")
	`DED_ASSERT(a_stall_cause, item_stall |-> result_valid && result_stall, "input stalled while output free")
	`DED_ASSERT(a_bad_text_end, result_valid && result.bad_escape |-> result.text_done && !result.byte_valid && result.decoded_byte == 8'h00, "error result malformed")
	`DED_ASSERT(a_mid_text, result_valid && !result.text_done |-> result.byte_valid && !result.bad_escape, "mid-text result without a byte")
	`DED_ASSERT_ALWAYS(a_reset_empty, $rose(arst_n) |-> !result_valid, "result shown on release of reset")

endmodule

bind dollar_escape_decoder dedec_checker u_dedec_checker (.*);

>>> test/tb.sv
// Self-checking testbench of the dollar escape decoder: predictor, driver, monitor and watchdog.
module tb;

	// Cycles without any transfer on either channel before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 2000;
	// Target number of input bytes for the whole run.
	localparam int TARGET_BYTES = 1100;
	// Cycles that are allowed to pass after the last expected result.
	localparam int TAIL_CYCLES = 8;
	// Length of the long receiver hold-off, and the result count that starts it.
	localparam int HOLDOFF_CYCLES = 60;
	localparam int HOLDOFF_AT = 300;

	// One byte waiting to be offered. When drain_first is set, the driver holds
	// the byte back until every expected result has come out of the block.
	typedef struct {
		dedec_pkg::in_item_t it;
		bit                  drain_first;
	} pending_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	dedec_pkg::in_item_t item = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	dedec_pkg::result_t  result;

	dollar_escape_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Characters that close a one-character escape after the dollar sign.
	string escape_set = "$'\"{}: lLnNpPrRtT";

	pending_t           send_q[$];
	dedec_pkg::result_t decoded_q[$];

	// Escape state of the predictor. Reset happens once, so these start at
	// the reset values and are returned there after every final byte.
	dedec_pkg::phase_t esc_phase = dedec_pkg::PH_PLAIN;
	logic [3:0]        hi_nib = 4'd0;
	logic              err_flag = 1'b0;

	int n_errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_texts = 0;
	int n_bad_texts = 0;
	int n_chars = 0;
	int n_queued = 0;
	int hold_left = 0;
	bit hold_done = 0;
	int stuck_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Prints one line per mismatch and keeps count of them.
	task automatic report_mismatch(input string msg);
		n_errors++;
		$display("mismatch at result %0d: %s", n_results, msg);
	endtask

	// Value of an ASCII hex digit of either case; returns 0 if c is no digit.
	function automatic bit nibble_of(input logic [7:0] c, output logic [3:0] v);
		v = 4'd0;
		if (c >= "0" && c <= "9") begin
			v = c[3:0];
			return 1'b1;
		end
		if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
			v = c[3:0] + 4'd9;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Character that a one-character escape stands for; 0 if c closes none.
	function automatic bit escaped_char(input logic [7:0] c, output logic [7:0] ch);
		ch = 8'h00;
		case (c)
			"$", "'", "\"", "{", "}", ":", " ": ch = c;
			"l", "L", "n", "N":                ch = dedec_pkg::LINE_FEED;
			"p", "P":                          ch = dedec_pkg::FORM_FEED;
			"r", "R":                          ch = dedec_pkg::CARRIAGE_RETURN;
			"t", "T":                          ch = dedec_pkg::HORIZONTAL_TAB;
			default:                           return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// Advances the escape state by one accepted byte and queues the result
	// that the byte must produce, if any.
	task automatic predict_decode(input dedec_pkg::in_item_t it);
		dedec_pkg::result_t r;
		logic [7:0]         ch;
		logic [7:0]         esc_ch;
		logic [3:0]         nib;
		bit                 have;
		bit                 is_hex;
		bit                 is_simple;
		have = 1'b0;
		ch = 8'h00;
		is_hex = nibble_of(it.text_byte, nib);
		is_simple = escaped_char(it.text_byte, esc_ch);
		// Once an error is pending, every byte up to the final one is dropped.
		if (!err_flag) begin
			case (esc_phase)
				dedec_pkg::PH_ESC: begin
					if (is_simple) begin
						ch = esc_ch;
						have = 1'b1;
						esc_phase = dedec_pkg::PH_PLAIN;
					end else if (is_hex) begin
						hi_nib = nib;
						esc_phase = dedec_pkg::PH_HEX;
					end else begin
						err_flag = 1'b1;
					end
				end
				dedec_pkg::PH_HEX: begin
					if (is_hex) begin
						ch = {hi_nib, nib};
						have = 1'b1;
						esc_phase = dedec_pkg::PH_PLAIN;
					end else begin
						err_flag = 1'b1;
					end
				end
				default: begin
					if (it.text_byte == dedec_pkg::DOLLAR_CHAR) begin
						esc_phase = dedec_pkg::PH_ESC;
					end else begin
						ch = it.text_byte;
						have = 1'b1;
					end
				end
			endcase
			// An escape still open at the end of the text spoils the text.
			if (it.is_final && esc_phase != dedec_pkg::PH_PLAIN)
				err_flag = 1'b1;
		end
		r.decoded_byte = ch;
		r.byte_valid = have;
		r.text_done = it.is_final;
		r.bad_escape = 1'b0;
		if (!it.is_final) begin
			if (have && !err_flag)
				decoded_q.push_back(r);
		end else begin
			// The final byte always gives exactly one result.
			if (err_flag) begin
				r.decoded_byte = 8'h00;
				r.byte_valid = 1'b0;
				r.bad_escape = 1'b1;
			end
			decoded_q.push_back(r);
			esc_phase = dedec_pkg::PH_PLAIN;
			hi_nib = 4'd0;
			err_flag = 1'b0;
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input bit fin, input bit drain);
		pending_t p;
		p.it.text_byte = b;
		p.it.is_final = fin;
		p.drain_first = drain;
		send_q.push_back(p);
		n_queued++;
	endtask

	// Queues a whole text given as a string; its last character is the final byte.
	task automatic queue_string(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i], i == s.len() - 1, 1'b0);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10)
			return 8'h30 + v;
		return (upper ? 8'h41 : 8'h61) + v - 8'd10;
	endfunction

	// Builds one random text. Most texts are made of well-formed pieces with
	// random content; a few broken escapes and some pure noise texts are mixed in.
	task automatic queue_random_text(input bit drain);
		logic [7:0] text[$];
		int         n_tok;
		int         kind;
		if ($urandom_range(99) < 10) begin
			n_tok = $urandom_range(1, 6);
			for (int i = 0; i < n_tok; i++)
				text.push_back(8'($urandom_range(255)));
		end else begin
			n_tok = $urandom_range(1, 10);
			for (int i = 0; i < n_tok; i++) begin
				kind = $urandom_range(99);
				if (kind < 40) begin
					text.push_back(8'($urandom_range(255)));
				end else if (kind < 65) begin
					text.push_back(dedec_pkg::DOLLAR_CHAR);
					text.push_back(escape_set[$urandom_range(escape_set.len() - 1)]);
				end else if (kind < 91) begin
					text.push_back(dedec_pkg::DOLLAR_CHAR);
					text.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
					text.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
				end else if (kind < 96) begin
					// Escape closed by an arbitrary byte, usually an illegal one.
					text.push_back(dedec_pkg::DOLLAR_CHAR);
					text.push_back(8'($urandom_range(255)));
				end else begin
					// Hex pair whose second digit is an arbitrary byte.
					text.push_back(dedec_pkg::DOLLAR_CHAR);
					text.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
					text.push_back(8'($urandom_range(255)));
				end
			end
			// Now and then leave an escape open at the end of the text.
			if ($urandom_range(99) < 5)
				text.push_back(dedec_pkg::DOLLAR_CHAR);
		end
		foreach (text[i])
			queue_byte(text[i], i == text.size() - 1, drain && i == 0);
	endtask

	// Stimulus: directed texts first, then random texts, then the end of the run.
	initial begin
		int n_text;
		// Byte extremes as one-byte texts.
		queue_byte(8'h00, 1'b1, 1'b0);
		queue_byte(8'hFF, 1'b1, 1'b0);
		// Escaped dollar, a line feed letter and a mixed-case hex pair that
		// completes on the final byte.
		queue_string("$$$n$Ff");
		// Hex pair of zeros, then a dollar sign as the final byte.
		queue_string("$00$");
		// Illegal escape character; the final byte that follows is dropped.
		queue_string("$gA");
		// First hex digit followed by a non-digit on the final byte.
		queue_string("$4z");
		// One-character escape closing on the final byte.
		queue_string("$t");
		// A lone dollar sign as a whole text.
		queue_string("$");
		n_text = 0;
		while (n_queued < TARGET_BYTES) begin
			// One text in the middle starts only after the block has drained.
			queue_random_text(n_text == 40);
			n_text++;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every byte has been taken and every result checked.
		do
			@(posedge clk);
		while (send_q.size() != 0 || item_valid || decoded_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d input bytes and %0d texts, %0d of them flagged bad;",
			n_items, n_texts, n_bad_texts);
		$display("%0d results were checked, %0d of them carrying a decoded character.",
			n_results, n_chars);
		if (n_errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Driver. A byte that is offered stays on the bus until its transfer;
	// between transfers the sender idles at random, except over a stretch in
	// the middle of the run where it offers a byte every cycle.
	always @(posedge clk) begin
		bit       quiet;
		pending_t nxt_p;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				predict_decode(item);
				n_items++;
			end
			if (!item_valid || !item_stall) begin
				quiet = n_items >= 500 && n_items < 700;
				if (send_q.size() == 0) begin
					item_valid <= 1'b0;
				end else if (send_q[0].drain_first && decoded_q.size() != 0) begin
					// Hold back until the block has delivered everything owed.
					item_valid <= 1'b0;
				end else if (!quiet && $urandom_range(99) < 30) begin
					item_valid <= 1'b0;
				end else begin
					nxt_p = send_q.pop_front();
					item_valid <= 1'b1;
					item <= nxt_p.it;
				end
			end
		end
	end

	// Monitor. Each result transfer is checked field by field against the
	// oldest prediction. The receiver stalls at random, not at all over a
	// stretch of the run, and once holds off for a long time so that the
	// block fills up and has to stall its input.
	always @(posedge clk) begin
		dedec_pkg::result_t want;
		bit                 quiet;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				n_results++;
				if (decoded_q.size() == 0) begin
					report_mismatch($sformatf("result %p arrived with nothing expected", result));
				end else begin
					want = decoded_q.pop_front();
					if (result.decoded_byte !== want.decoded_byte)
						report_mismatch($sformatf("decoded_byte %h, expected %h",
							result.decoded_byte, want.decoded_byte));
					if (result.byte_valid !== want.byte_valid)
						report_mismatch($sformatf("byte_valid %b, expected %b",
							result.byte_valid, want.byte_valid));
					if (result.text_done !== want.text_done)
						report_mismatch($sformatf("text_done %b, expected %b",
							result.text_done, want.text_done));
					if (result.bad_escape !== want.bad_escape)
						report_mismatch($sformatf("bad_escape %b, expected %b",
							result.bad_escape, want.bad_escape));
					if (want.text_done)
						n_texts++;
					if (want.bad_escape)
						n_bad_texts++;
					if (want.byte_valid)
						n_chars++;
				end
			end
			quiet = n_results >= 450 && n_results < 650;
			if (hold_left != 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else if (!hold_done && n_results >= HOLDOFF_AT) begin
				hold_done = 1'b1;
				hold_left = HOLDOFF_CYCLES - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= !quiet && $urandom_range(99) < 30;
			end
		end
	end

	// Watchdog: a run in which neither channel moves for too long is hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("TEST FAILED");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

endmodule

>>> files.f
+incdir+rtl
rtl/dedec_pkg.sv
rtl/dedec_core.sv
rtl/dollar_escape_decoder.sv
rtl/dedec_checker.sv
test/tb.sv
